>>> hw/rtl/multilevel_feedback_scheduler_top_defines.svh
// assertion macros for the multilevel feedback scheduler
// used by multilevel_feedback_scheduler_top, expects aclk and aresetn in scope
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH

// consequence checked in the same cycle
`define MFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the next cycle
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mfs_pkg.sv
// shared types and constants of the multilevel feedback scheduler
// no dependencies
package mfs_pkg;

    localparam int TASK_SLOTS_DEF = 64;
    localparam int LEVELS_DEF     = 8;

    localparam int ID_W      = 6;
    localparam int OP_W      = 3;
    localparam int LVL_W     = 3;
    localparam int QNT_W     = 8;
    localparam int QLIM_W    = 7;
    localparam int RC_W      = 3;
    localparam int SLV_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    localparam logic [SLV_W-1:0]  LVL_BLOCKED       = '0;
    localparam logic [SLV_W-1:0]  LVL_FLOOR         = '0;
    localparam logic [QLIM_W-1:0] QUANTUM_LIMIT_RST = 7'd8;
    localparam logic [ID_W-1:0]   IDLE_SLOT_RST     = 6'd0;
    localparam logic [ID_W-1:0]   SHELL_SLOT_RST    = 6'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK, OP_ADD, OP_BLOCK, OP_UNBLOCK, OP_TOGGLE, OP_SET_PRIO, OP_KILL, OP_YIELD
    } opcode_t;

    typedef enum logic [1:0] {
        SL_EMPTY, SL_READY, SL_RUNNING, SL_BLOCKED
    } slot_state_t;

    typedef enum logic [RC_W-1:0] {
        RC_OK, RC_NOT_FOUND, RC_INVALID_TASK, RC_SAME_PRIORITY, RC_INVALID_PRIORITY,
        RC_SAME_STATUS
    } rc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM_LIMIT, CFG_IDLE_SLOT, CFG_SHELL_SLOT
    } cfg_idx_t;

    typedef struct packed {
        slot_state_t       status;
        logic [SLV_W-1:0]  level;
        logic [QNT_W-1:0]  quantum;
    } slot_t;

endpackage

>>> hw/rtl/mfs_slot_table.sv
// slot table memory: status, level and quantum per task slot
// depends on mfs_pkg; entries never written read as empty
module mfs_slot_table #(
    parameter int SLOTS = mfs_pkg::TASK_SLOTS_DEF,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [SW-1:0]   rd_addr,
    output mfs_pkg::slot_t  rd_data,
    input  logic            wr_en,
    input  logic [SW-1:0]   wr_addr,
    input  mfs_pkg::slot_t  wr_data
);
    import mfs_pkg::*;

    slot_t            mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    slot_t            rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/mfs_link_ram.sv
// queue link memory: next slot of each queued slot
// depends on mfs_pkg for the default depth
module mfs_link_ram #(
    parameter int SLOTS = mfs_pkg::TASK_SLOTS_DEF,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic          aclk,
    input  logic [SW-1:0] rd_addr,
    output logic [SW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [SW-1:0] wr_data
);
    logic [SW-1:0] mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/multilevel_feedback_scheduler_top.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | opcode, task_id, level, initial_quantum
// m_      | out       | m_valid / m_ready  | running_task, switched, status_code, result_level
// cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
// one command at a time: decode, write and finish for a plain command, result loaded in the finish state
// a reschedule adds a read of the outgoing task, its requeue and a pop of the next task
// a removal from a queue checks the head, then walks the links, up to the queue length
// synchronous reset clears slot valid bits and queues; no clearing pass
// a held result stalls the next completion, not the next transfer in
// top level: sequencer, queue heads and tails, configuration, result register
// depends on mfs_pkg, mfs_slot_table, mfs_link_ram and the defines header
`include "multilevel_feedback_scheduler_top_defines.svh"

module multilevel_feedback_scheduler_top #(
    parameter int TASK_SLOTS = mfs_pkg::TASK_SLOTS_DEF,
    parameter int LEVELS     = mfs_pkg::LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mfs_pkg::OP_W-1:0]      s_opcode,
    input  logic [mfs_pkg::ID_W-1:0]      s_task_id,
    input  logic [mfs_pkg::LVL_W-1:0]     s_level,
    input  logic [mfs_pkg::QNT_W-1:0]     s_initial_quantum,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mfs_pkg::ID_W-1:0]      m_running_task,
    output logic                          m_switched,
    output logic [mfs_pkg::RC_W-1:0]      m_status_code,
    output logic [mfs_pkg::LVL_W-1:0]     m_result_level
);
    import mfs_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(LEVELS);
    localparam logic [SLV_W-1:0] LVL_TOP = SLV_W'(LEVELS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEC, ST_REM, ST_REM_HN, ST_WALK, ST_SPLICE, ST_WR,
        ST_RS_RD, ST_RS_DEC, ST_POP, ST_RUN, ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [QLIM_W-1:0] qlim_reg, qlim_next;
    logic [ID_W-1:0]   idle_slot_reg, idle_slot_next;
    logic [ID_W-1:0]   shell_slot_reg, shell_slot_next;

    logic [ID_W-1:0]   cur_reg, cur_next;
    logic [QNT_W-1:0]  ticks_reg, ticks_next;
    logic [ID_W-1:0]   before_reg, before_next;
    opcode_t           op_reg, op_next;
    logic [ID_W-1:0]   t_reg, t_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [QNT_W-1:0]  iq_reg, iq_next;
    rc_t               rc_reg, rc_next;
    logic [LVL_W-1:0]  rl_reg, rl_next;

    logic [SW-1:0]     tgt_reg, tgt_next;
    logic              rm_en_reg, rm_en_next;
    logic [LW-1:0]     rm_lv_reg, rm_lv_next;
    logic              wr_en_reg, wr_en_next;
    slot_t             wr_data_reg, wr_data_next;
    logic              push_en_reg, push_en_next;
    logic [LW-1:0]     push_lv_reg, push_lv_next;
    logic              rs_en_reg, rs_en_next;
    logic              pop_en_reg, pop_en_next;
    logic [SW-1:0]     p_reg, p_next;
    logic [LW-1:0]     pop_lv_reg, pop_lv_next;
    logic              pop_last_reg, pop_last_next;

    logic [LEVELS-1:0] qvalid_reg, qvalid_next;
    logic [SW-1:0]     qhead_reg [LEVELS];
    logic [SW-1:0]     qhead_next [LEVELS];
    logic [SW-1:0]     qtail_reg [LEVELS];
    logic [SW-1:0]     qtail_next [LEVELS];

    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_task_reg, m_task_next;
    logic              m_sw_reg, m_sw_next;
    rc_t               m_rc_reg, m_rc_next;
    logic [LVL_W-1:0]  m_rl_reg, m_rl_next;

    logic [SW-1:0]     slot_rd_addr;
    slot_t             slot_rd_data;
    logic              slot_wr_en;
    logic [SW-1:0]     slot_wr_addr;
    slot_t             slot_wr_data;
    logic [SW-1:0]     link_rd_addr;
    logic [SW-1:0]     link_rd_data;
    logic              link_wr_en;
    logic [SW-1:0]     link_wr_addr;
    logic [SW-1:0]     link_wr_data;

    logic              any_valid;
    logic [LW-1:0]     hi_lv;
    logic              in_range;
    logic              live;
    logic              lvl_ok;
    logic              cur_in_range;
    logic [SLV_W-1:0]  dem_lv;
    logic [QNT_W-1:0]  dbl_q;

    mfs_slot_table #(.SLOTS(TASK_SLOTS)) u_slot_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data)
    );

    mfs_link_ram #(.SLOTS(TASK_SLOTS)) u_link_ram (
        .aclk    (aclk),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    // highest non-empty level
    always_comb begin
        any_valid = 1'b0;
        hi_lv     = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (qvalid_reg[i]) begin
                any_valid = 1'b1;
                hi_lv     = LW'(i);
            end
        end
    end

    assign in_range     = 32'(t_reg) < TASK_SLOTS;
    assign live         = in_range && (slot_rd_data.status != SL_EMPTY);
    assign lvl_ok       = 32'(lvl_reg) < LEVELS;
    assign cur_in_range = 32'(cur_reg) < TASK_SLOTS;
    assign dem_lv       = (slot_rd_data.level > LVL_FLOOR) ?
                          slot_rd_data.level - SLV_W'(1) : slot_rd_data.level;
    assign dbl_q        = (slot_rd_data.quantum <= {1'b0, qlim_reg}) ?
                          {slot_rd_data.quantum[QNT_W-2:0], 1'b0} : slot_rd_data.quantum;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_running_task = m_task_reg;
    assign m_switched     = m_sw_reg;
    assign m_status_code  = m_rc_reg;
    assign m_result_level = m_rl_reg;

    always_comb begin
        state_next      = state_reg;
        qlim_next       = qlim_reg;
        idle_slot_next  = idle_slot_reg;
        shell_slot_next = shell_slot_reg;
        cur_next        = cur_reg;
        ticks_next      = ticks_reg;
        before_next     = before_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        lvl_next        = lvl_reg;
        iq_next         = iq_reg;
        rc_next         = rc_reg;
        rl_next         = rl_reg;
        tgt_next        = tgt_reg;
        rm_en_next      = rm_en_reg;
        rm_lv_next      = rm_lv_reg;
        wr_en_next      = wr_en_reg;
        wr_data_next    = wr_data_reg;
        push_en_next    = push_en_reg;
        push_lv_next    = push_lv_reg;
        rs_en_next      = rs_en_reg;
        pop_en_next     = pop_en_reg;
        p_next          = p_reg;
        pop_lv_next     = pop_lv_reg;
        pop_last_next   = pop_last_reg;
        qvalid_next     = qvalid_reg;
        qhead_next      = qhead_reg;
        qtail_next      = qtail_reg;
        m_task_next     = m_task_reg;
        m_sw_next       = m_sw_reg;
        m_rc_next       = m_rc_reg;
        m_rl_next       = m_rl_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        slot_rd_addr = '0;
        slot_wr_en   = 1'b0;
        slot_wr_addr = tgt_reg;
        slot_wr_data = wr_data_reg;
        link_rd_addr = '0;
        link_wr_en   = 1'b0;
        link_wr_addr = p_reg;
        link_wr_data = link_rd_data;

        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_QUANTUM_LIMIT: qlim_next = cfg_wdata;
                CFG_IDLE_SLOT:     idle_slot_next = cfg_wdata[ID_W-1:0];
                CFG_SHELL_SLOT:    shell_slot_next = cfg_wdata[ID_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                slot_rd_addr = SW'(s_task_id);
                if (s_valid) begin
                    op_next     = opcode_t'(s_opcode);
                    t_next      = s_task_id;
                    lvl_next    = s_level;
                    iq_next     = s_initial_quantum;
                    before_next = cur_reg;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                rc_next      = RC_OK;
                rl_next      = '0;
                rm_en_next   = 1'b0;
                wr_en_next   = 1'b0;
                push_en_next = 1'b0;
                rs_en_next   = 1'b0;
                pop_en_next  = 1'b0;
                tgt_next     = SW'(t_reg);
                rm_lv_next   = LW'(slot_rd_data.level);
                push_lv_next = LW'(lvl_reg);
                wr_data_next = slot_rd_data;
                unique case (op_reg) inside
                    OP_TICK: begin
                        if (ticks_reg != '0) begin
                            ticks_next = ticks_reg - QNT_W'(1);
                        end else begin
                            rs_en_next = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (!in_range || slot_rd_data.status != SL_EMPTY) begin
                            rc_next = RC_INVALID_TASK;
                        end else if (!lvl_ok) begin
                            rc_next = RC_INVALID_PRIORITY;
                        end else begin
                            wr_en_next   = 1'b1;
                            wr_data_next = '{SL_READY, SLV_W'(lvl_reg), iq_reg};
                            push_en_next = 1'b1;
                        end
                    end
                    OP_BLOCK, OP_UNBLOCK, OP_TOGGLE: begin
                        if (!live) begin
                            rc_next = RC_NOT_FOUND;
                        end else if (op_reg == OP_UNBLOCK ||
                                     (op_reg == OP_TOGGLE &&
                                      slot_rd_data.status == SL_BLOCKED)) begin
                            if (slot_rd_data.status != SL_BLOCKED) begin
                                rc_next = RC_SAME_STATUS;
                            end else begin
                                wr_en_next   = 1'b1;
                                wr_data_next = '{SL_READY, LVL_TOP, QNT_W'(1)};
                                push_en_next = 1'b1;
                                push_lv_next = LW'(LVL_TOP);
                                ticks_next   = '0;
                            end
                        end else if (t_reg == idle_slot_reg) begin
                            rc_next = RC_INVALID_TASK;
                        end else if (slot_rd_data.status == SL_BLOCKED) begin
                            rc_next = RC_SAME_STATUS;
                        end else begin
                            rm_en_next   = (slot_rd_data.status == SL_READY);
                            wr_en_next   = 1'b1;
                            wr_data_next = '{SL_BLOCKED, LVL_BLOCKED,
                                             slot_rd_data.quantum};
                            rs_en_next   = (op_reg == OP_TOGGLE) && (t_reg == cur_reg);
                        end
                    end
                    OP_SET_PRIO: begin
                        if (!live) begin
                            rc_next = RC_NOT_FOUND;
                        end else if (t_reg == idle_slot_reg) begin
                            rc_next = RC_INVALID_TASK;
                        end else if (SLV_W'(lvl_reg) == slot_rd_data.level &&
                                     slot_rd_data.status != SL_RUNNING) begin
                            rc_next = RC_SAME_PRIORITY;
                        end else if (!lvl_ok) begin
                            rc_next = RC_INVALID_PRIORITY;
                        end else begin
                            rm_en_next         = (slot_rd_data.status == SL_READY);
                            push_en_next       = (slot_rd_data.status == SL_READY);
                            wr_en_next         = 1'b1;
                            wr_data_next.level = SLV_W'(lvl_reg);
                            rl_next            = lvl_reg;
                        end
                    end
                    OP_KILL: begin
                        if (!live) begin
                            rc_next = RC_NOT_FOUND;
                        end else if (t_reg == idle_slot_reg || t_reg == shell_slot_reg) begin
                            rc_next = RC_INVALID_TASK;
                        end else begin
                            rm_en_next   = (slot_rd_data.status == SL_READY);
                            wr_en_next   = 1'b1;
                            wr_data_next = '0;
                            rs_en_next   = (t_reg == cur_reg);
                        end
                    end
                    OP_YIELD: begin
                        ticks_next = '0;
                        rs_en_next = 1'b1;
                    end
                    default: ;
                endcase
                state_next = rm_en_next ? ST_REM : ST_WR;
            end
            ST_REM: begin
                link_rd_addr = qhead_reg[rm_lv_reg];
                if (!qvalid_reg[rm_lv_reg]) begin
                    state_next = ST_WR;
                end else if (qhead_reg[rm_lv_reg] == tgt_reg) begin
                    if (qhead_reg[rm_lv_reg] == qtail_reg[rm_lv_reg]) begin
                        qvalid_next[rm_lv_reg] = 1'b0;
                        state_next             = ST_WR;
                    end else begin
                        state_next = ST_REM_HN;
                    end
                end else if (qhead_reg[rm_lv_reg] == qtail_reg[rm_lv_reg]) begin
                    state_next = ST_WR;
                end else begin
                    p_next     = qhead_reg[rm_lv_reg];
                    state_next = ST_WALK;
                end
            end
            ST_REM_HN: begin
                qhead_next[rm_lv_reg] = link_rd_data;
                state_next            = ST_WR;
            end
            ST_WALK: begin
                link_rd_addr = link_rd_data;
                if (link_rd_data == tgt_reg) begin
                    state_next = ST_SPLICE;
                end else if (link_rd_data == qtail_reg[rm_lv_reg]) begin
                    state_next = ST_WR;
                end else begin
                    p_next = link_rd_data;
                end
            end
            ST_SPLICE: begin
                // predecessor skips the removed slot
                link_wr_en = 1'b1;
                if (qtail_reg[rm_lv_reg] == tgt_reg) begin
                    qtail_next[rm_lv_reg] = p_reg;
                end
                state_next = ST_WR;
            end
            ST_WR: begin
                slot_wr_en = wr_en_reg;
                if (push_en_reg) begin
                    if (!qvalid_reg[push_lv_reg]) begin
                        qvalid_next[push_lv_reg] = 1'b1;
                        qhead_next[push_lv_reg]  = tgt_reg;
                    end else begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = qtail_reg[push_lv_reg];
                        link_wr_data = tgt_reg;
                    end
                    qtail_next[push_lv_reg] = tgt_reg;
                end
                if (rs_en_reg) begin
                    state_next = ST_RS_RD;
                end else if (pop_en_reg) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_RS_RD: begin
                slot_rd_addr = SW'(cur_reg);
                rs_en_next   = 1'b0;
                pop_en_next  = 1'b1;
                state_next   = cur_in_range ? ST_RS_DEC : ST_POP;
            end
            ST_RS_DEC: begin
                if (slot_rd_data.status == SL_RUNNING || slot_rd_data.status == SL_READY) begin
                    // demote down to the floor, double the quantum while within the limit, requeue the outgoing task
                    tgt_next     = SW'(cur_reg);
                    rm_en_next   = (slot_rd_data.status == SL_READY);
                    rm_lv_next   = LW'(slot_rd_data.level);
                    wr_en_next   = 1'b1;
                    wr_data_next = '{SL_READY, dem_lv, dbl_q};
                    push_en_next = 1'b1;
                    push_lv_next = LW'(dem_lv);
                    state_next   = (slot_rd_data.status == SL_READY) ? ST_REM : ST_WR;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                slot_rd_addr = qhead_reg[hi_lv];
                link_rd_addr = qhead_reg[hi_lv];
                pop_en_next  = 1'b0;
                if (!any_valid) begin
                    cur_next   = idle_slot_reg;
                    ticks_next = '0;
                    state_next = ST_FIN;
                end else begin
                    p_next        = qhead_reg[hi_lv];
                    pop_lv_next   = hi_lv;
                    pop_last_next = (qhead_reg[hi_lv] == qtail_reg[hi_lv]);
                    if (qhead_reg[hi_lv] == qtail_reg[hi_lv]) begin
                        qvalid_next[hi_lv] = 1'b0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!pop_last_reg) begin
                    qhead_next[pop_lv_reg] = link_rd_data;
                end
                slot_wr_en   = 1'b1;
                slot_wr_addr = p_reg;
                slot_wr_data = '{SL_RUNNING, slot_rd_data.level, slot_rd_data.quantum};
                ticks_next   = slot_rd_data.quantum;
                cur_next     = ID_W'(p_reg);
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_task_next  = cur_reg;
                    m_sw_next    = (cur_reg != before_reg);
                    m_rc_next    = rc_reg;
                    m_rl_next    = rl_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            qlim_reg       <= QUANTUM_LIMIT_RST;
            idle_slot_reg  <= IDLE_SLOT_RST;
            shell_slot_reg <= SHELL_SLOT_RST;
            cur_reg        <= '0;
            ticks_reg      <= '0;
            rs_en_reg      <= 1'b0;
            pop_en_reg     <= 1'b0;
            qvalid_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            qlim_reg       <= qlim_next;
            idle_slot_reg  <= idle_slot_next;
            shell_slot_reg <= shell_slot_next;
            cur_reg        <= cur_next;
            ticks_reg      <= ticks_next;
            rs_en_reg      <= rs_en_next;
            pop_en_reg     <= pop_en_next;
            qvalid_reg     <= qvalid_next;
            m_valid_reg    <= m_valid_next;
        end
        before_reg    <= before_next;
        op_reg        <= op_next;
        t_reg         <= t_next;
        lvl_reg       <= lvl_next;
        iq_reg        <= iq_next;
        rc_reg        <= rc_next;
        rl_reg        <= rl_next;
        tgt_reg       <= tgt_next;
        rm_en_reg     <= rm_en_next;
        rm_lv_reg     <= rm_lv_next;
        wr_en_reg     <= wr_en_next;
        wr_data_reg   <= wr_data_next;
        push_en_reg   <= push_en_next;
        push_lv_reg   <= push_lv_next;
        p_reg         <= p_next;
        pop_lv_reg    <= pop_lv_next;
        pop_last_reg  <= pop_last_next;
        qhead_reg     <= qhead_next;
        qtail_reg     <= qtail_next;
        m_task_reg    <= m_task_next;
        m_sw_reg      <= m_sw_next;
        m_rc_reg      <= m_rc_next;
        m_rl_reg      <= m_rl_next;
    end

    `MFS_ASSERT_NEXT(a_transfer_decoded, s_valid && s_ready, state_reg == ST_DEC, "transfer in not decoded")
    `MFS_ASSERT_NEXT(a_idle_fallback, state_reg == ST_POP && qvalid_reg == '0, cur_reg == $past(idle_slot_reg) && ticks_reg == '0, "empty queues did not select idle slot")
    `MFS_ASSERT_NEXT(a_result_held, state_reg == ST_FIN && m_valid_reg && !m_ready, state_reg == ST_FIN && m_valid_reg, "pending result overwritten")

endmodule

>>> tb/sv/tb_multilevel_feedback_scheduler_top.sv
// self-checking testbench of multilevel_feedback_scheduler_top
// directed table then random commands, checked against an in-bench scheduler predictor
// depends on mfs_pkg and the scheduler rtl
module tb_multilevel_feedback_scheduler_top;
    import mfs_pkg::*;

    localparam int NSLOT = 64;
    localparam int NLVL  = 8;

    typedef struct {
        logic [ID_W-1:0]  run;
        logic             sw;
        rc_t              rc;
        logic [LVL_W-1:0] rl;
    } sched_result_t;

    typedef struct {
        opcode_t          op;
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] lvl;
        logic [QNT_W-1:0] qnt;
        bit               typed;
        sched_result_t    res;
    } cmd_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode;
    logic [ID_W-1:0]      s_task_id;
    logic [LVL_W-1:0]     s_level;
    logic [QNT_W-1:0]     s_initial_quantum;
    logic                 m_valid;
    logic                 m_ready;
    logic [ID_W-1:0]      m_running_task;
    logic                 m_switched;
    logic [RC_W-1:0]      m_status_code;
    logic [LVL_W-1:0]     m_result_level;

    multilevel_feedback_scheduler_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_task_id(s_task_id),
        .s_level(s_level), .s_initial_quantum(s_initial_quantum),
        .m_valid(m_valid), .m_ready(m_ready), .m_running_task(m_running_task),
        .m_switched(m_switched), .m_status_code(m_status_code),
        .m_result_level(m_result_level)
    );

    // scheduler state mirror
    slot_state_t      sl_status [NSLOT];
    logic [LVL_W-1:0] sl_level  [NSLOT];
    logic [QNT_W-1:0] sl_quant  [NSLOT];
    logic [ID_W-1:0]  sl_link   [NSLOT];
    logic [ID_W-1:0]  lv_head   [NLVL];
    logic [ID_W-1:0]  lv_tail   [NLVL];
    bit               lv_busy   [NLVL];
    logic [ID_W-1:0]  cur_task;
    logic [QNT_W-1:0] ticks_left;
    int unsigned      qlimit, idle_id, shell_id;

    sched_result_t    pending_results [$];
    int               n_err;
    bit               idle_en;
    bit               hold_req;

    function automatic void lv_push(int lv, logic [ID_W-1:0] s);
        sl_link[s] = '0;
        if (!lv_busy[lv]) begin
            lv_head[lv] = s;
            lv_tail[lv] = s;
            lv_busy[lv] = 1;
        end else begin
            sl_link[lv_tail[lv]] = s;
            lv_tail[lv] = s;
        end
    endfunction

    function automatic logic [ID_W-1:0] lv_pop(int lv);
        logic [ID_W-1:0] s;
        s = lv_head[lv];
        if (s == lv_tail[lv]) lv_busy[lv] = 0;
        else lv_head[lv] = sl_link[s];
        return s;
    endfunction

    function automatic void lv_unlink(int lv, logic [ID_W-1:0] s);
        logic [ID_W-1:0] p, n;
        if (!lv_busy[lv]) return;
        if (lv_head[lv] == s) begin
            void'(lv_pop(lv));
            return;
        end
        p = lv_head[lv];
        for (int i = 0; i < NSLOT && p != lv_tail[lv]; i++) begin
            n = sl_link[p];
            if (n == s) begin
                sl_link[p] = sl_link[s];
                if (lv_tail[lv] == s) lv_tail[lv] = p;
                return;
            end
            p = n;
        end
    endfunction

    function automatic void pick_next();
        logic [ID_W-1:0] c, s;
        int q;
        c = cur_task;
        if (sl_status[c] == SL_RUNNING || sl_status[c] == SL_READY) begin
            q = sl_quant[c];
            if (sl_status[c] == SL_READY) lv_unlink(sl_level[c], c);
            if (sl_level[c] > 0) sl_level[c] = sl_level[c] - 1'b1;
            sl_status[c] = SL_READY;
            lv_push(sl_level[c], c);
            if (q <= qlimit) sl_quant[c] = QNT_W'(q * 2);
        end
        for (int lv = NLVL - 1; lv >= 0; lv--) begin
            if (lv_busy[lv]) begin
                s = lv_pop(lv);
                sl_status[s] = SL_RUNNING;
                ticks_left = sl_quant[s];
                cur_task = s;
                return;
            end
        end
        cur_task = ID_W'(idle_id);
        ticks_left = '0;
    endfunction

    function automatic rc_t block_task(logic [ID_W-1:0] t);
        if (t == idle_id) return RC_INVALID_TASK;
        if (sl_status[t] == SL_BLOCKED) return RC_SAME_STATUS;
        if (sl_status[t] == SL_READY) lv_unlink(sl_level[t], t);
        sl_status[t] = SL_BLOCKED;
        sl_level[t] = '0;
        return RC_OK;
    endfunction

    function automatic rc_t unblock_task(logic [ID_W-1:0] t);
        if (sl_status[t] != SL_BLOCKED) return RC_SAME_STATUS;
        sl_level[t] = LVL_W'(NLVL - 1);
        sl_status[t] = SL_READY;
        lv_push(NLVL - 1, t);
        sl_quant[t] = QNT_W'(1);
        ticks_left = '0;
        return RC_OK;
    endfunction

    function automatic sched_result_t sched_step(opcode_t op, logic [ID_W-1:0] t,
                                                 logic [LVL_W-1:0] lvl, logic [QNT_W-1:0] iq);
        sched_result_t r;
        logic [ID_W-1:0] prev;
        bit live;
        prev = cur_task;
        live = sl_status[t] != SL_EMPTY;
        r.rc = RC_OK;
        r.rl = '0;
        case (op)
            OP_TICK: begin
                if (ticks_left > 0) ticks_left = ticks_left - 1'b1;
                else pick_next();
            end
            OP_ADD: begin
                if (live) r.rc = RC_INVALID_TASK;
                else begin
                    sl_status[t] = SL_READY;
                    sl_level[t] = lvl;
                    sl_quant[t] = iq;
                    lv_push(lvl, t);
                end
            end
            OP_BLOCK:   r.rc = live ? block_task(t) : RC_NOT_FOUND;
            OP_UNBLOCK: r.rc = live ? unblock_task(t) : RC_NOT_FOUND;
            OP_TOGGLE: begin
                if (!live) r.rc = RC_NOT_FOUND;
                else if (sl_status[t] == SL_BLOCKED) r.rc = unblock_task(t);
                else begin
                    r.rc = block_task(t);
                    if (r.rc == RC_OK && t == cur_task) pick_next();
                end
            end
            OP_SET_PRIO: begin
                if (!live) r.rc = RC_NOT_FOUND;
                else if (t == idle_id) r.rc = RC_INVALID_TASK;
                else if (lvl == sl_level[t] && sl_status[t] != SL_RUNNING)
                    r.rc = RC_SAME_PRIORITY;
                else begin
                    if (sl_status[t] == SL_READY) begin
                        lv_unlink(sl_level[t], t);
                        lv_push(lvl, t);
                    end
                    sl_level[t] = lvl;
                    r.rl = lvl;
                end
            end
            OP_KILL: begin
                if (!live) r.rc = RC_NOT_FOUND;
                else if (t == idle_id || t == shell_id) r.rc = RC_INVALID_TASK;
                else begin
                    if (sl_status[t] == SL_READY) lv_unlink(sl_level[t], t);
                    sl_status[t] = SL_EMPTY;
                    sl_level[t] = '0;
                    sl_quant[t] = '0;
                    if (t == cur_task) pick_next();
                end
            end
            default: begin
                ticks_left = '0;
                pick_next();
            end
        endcase
        r.run = cur_task;
        r.sw = cur_task != prev;
        return r;
    endfunction

    // directed commands from reset, typed results where obvious
    cmd_row_t cmd_tab [24] = '{
        '{OP_TICK,     6'd0,  3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_BLOCK,    6'd5,  3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_NOT_FOUND, 3'd0}},
        '{OP_ADD,      6'd5,  3'd7, 8'd254, 1, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_ADD,      6'd5,  3'd0, 8'd1,   1, '{6'd0, 1'b0, RC_INVALID_TASK, 3'd0}},
        '{OP_ADD,      6'd63, 3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_ADD,      6'd1,  3'd3, 8'd1,   1, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_ADD,      6'd0,  3'd2, 8'd3,   1, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_KILL,     6'd1,  3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_INVALID_TASK, 3'd0}},
        '{OP_SET_PRIO, 6'd63, 3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_SAME_PRIORITY, 3'd0}},
        '{OP_UNBLOCK,  6'd63, 3'd0, 8'd0,   1, '{6'd0, 1'b0, RC_SAME_STATUS, 3'd0}},
        '{OP_SET_PRIO, 6'd0,  3'd5, 8'd0,   1, '{6'd0, 1'b0, RC_INVALID_TASK, 3'd0}},
        '{OP_TICK,     6'd0,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_YIELD,    6'd0,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_TOGGLE,   6'd63, 3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_BLOCK,    6'd63, 3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_TOGGLE,   6'd63, 3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_SET_PRIO, 6'd1,  3'd7, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_BLOCK,    6'd0,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_TOGGLE,   6'd1,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_KILL,     6'd5,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_ADD,      6'd42, 3'd7, 8'd255, 0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_YIELD,    6'd0,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_KILL,     6'd42, 3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}},
        '{OP_TICK,     6'd0,  3'd0, 8'd0,   0, '{6'd0, 1'b0, RC_OK, 3'd0}}
    };

    task automatic send_cmd(cmd_row_t row);
        sched_result_t r;
        if (idle_en && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid           <= 1'b1;
        s_opcode          <= row.op;
        s_task_id         <= row.id;
        s_level           <= row.lvl;
        s_initial_quantum <= row.qnt;
        do @(posedge aclk); while (!s_ready);
        r = sched_step(row.op, row.id, row.lvl, row.qnt);
        pending_results.push_back(row.typed ? row.res : r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_QUANTUM_LIMIT: qlimit = val;
            CFG_IDLE_SLOT:     idle_id = val;
            default:           shell_id = val;
        endcase
        @(posedge aclk);
    endtask

    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int k;
        k = $urandom_range(99);
        c.op = k < 25 ? OP_TICK : k < 45 ? OP_ADD : k < 52 ? OP_BLOCK : k < 59 ? OP_UNBLOCK :
               k < 68 ? OP_TOGGLE : k < 78 ? OP_SET_PRIO : k < 88 ? OP_KILL : OP_YIELD;
        c.id  = ID_W'(($urandom_range(99) < 85) ? $urandom_range(11) : $urandom_range(63));
        c.lvl = LVL_W'($urandom_range(7));
        c.qnt = QNT_W'(($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(255));
        c.typed = 0;
        return c;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: checking and backpressure
    initial begin
        sched_result_t want;
        int hold_cnt;
        m_ready  <= 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result transfer, task %0d",
                                              m_running_task);
                end else begin
                    want = pending_results.pop_front();
                    if (m_running_task !== want.run || m_switched !== want.sw ||
                        m_status_code !== want.rc || m_result_level !== want.rl) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp run %0d sw %0d rc %0d lvl %0d, got %0d %0d %0d %0d",
                                     want.run, want.sw, want.rc, want.rl, m_running_task,
                                     m_switched, m_status_code, m_result_level);
                    end
                end
            end
            if (hold_req && hold_cnt == 0) begin
                hold_req = 0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_en && $urandom_range(99) < 38);
            end
        end
    end

    initial begin
        automatic int unsigned ph_lim   [5] = '{8, 1, 127, 3, 127};
        automatic int unsigned ph_idle  [5] = '{0, 63, 5, 2, 0};
        automatic int unsigned ph_shell [5] = '{1, 0, 63, 2, 1};
        n_err     = 0;
        idle_en   = 1;
        hold_req  = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_opcode  <= '0;
        s_task_id <= '0;
        s_level   <= '0;
        s_initial_quantum <= '0;
        for (int i = 0; i < NSLOT; i++) begin
            sl_status[i] = SL_EMPTY;
            sl_level[i]  = '0;
            sl_quant[i]  = '0;
            sl_link[i]   = '0;
        end
        for (int i = 0; i < NLVL; i++) begin
            lv_head[i] = '0;
            lv_tail[i] = '0;
            lv_busy[i] = 0;
        end
        cur_task   = '0;
        ticks_left = '0;
        qlimit     = QUANTUM_LIMIT_RST;
        idle_id    = IDLE_SLOT_RST;
        shell_id   = SHELL_SLOT_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (cmd_tab[i]) send_cmd(cmd_tab[i]);
        drain_results();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_QUANTUM_LIMIT, ph_lim[ph]);
            write_reg(CFG_IDLE_SLOT, ph_idle[ph]);
            write_reg(CFG_SHELL_SLOT, ph_shell[ph]);
            idle_en = (ph != 3);
            for (int n = 0; n < 166; n++) begin
                if (ph == 1 && n == 40) hold_req = 1;
                if (ph == 2 && n == 80) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending_results.size() != 0);
                end
                send_cmd(random_cmd());
            end
            drain_results();
        end

        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> multilevel_feedback_scheduler_top.f
+incdir+hw/rtl
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_slot_table.sv
hw/rtl/mfs_link_ram.sv
hw/rtl/multilevel_feedback_scheduler_top.sv
tb/sv/tb_multilevel_feedback_scheduler_top.sv
